// ===== sv/est_pkg.sv =====
// Shared types and constants for the extent sector translator.
// Used by the top level and the engine; depends on nothing else.
package est_pkg;

  localparam int EXT_SLOTS   = 64;
  localparam int REMAP_SLOTS = 256;

  localparam int EXT_AW = (EXT_SLOTS > 1) ? $clog2(EXT_SLOTS) : 1;
  localparam int EXT_CW = $clog2(EXT_SLOTS + 1);
  localparam int REM_AW = (REMAP_SLOTS > 1) ? $clog2(REMAP_SLOTS) : 1;
  localparam int REM_CW = $clog2(REMAP_SLOTS + 1);

  localparam int CFG_DW = 32;

  localparam logic [9:0] SECTOR_BYTES = 10'd512;

  typedef logic [EXT_AW-1:0] ext_addr_t;
  typedef logic [EXT_CW-1:0] ext_cnt_t;
  typedef logic [REM_AW-1:0] rem_addr_t;
  typedef logic [REM_CW-1:0] rem_cnt_t;

  typedef enum logic [1:0] {
    REQ_LOAD_EXTENT = 2'd0,
    REQ_LOAD_REMAP  = 2'd1,
    REQ_TRANSLATE   = 2'd2,
    REQ_RESERVED    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_FILE_LENGTH   = 2'd0,
    CFG_EXTENTS_USED  = 2'd1,
    CFG_REMAPS_USED   = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  slot_index;
    logic [31:0] extent_logical_first;
    logic [31:0] extent_sector_count;
    logic [31:0] extent_physical_first;
    logic [31:0] bad_sector;
    logic [31:0] spare_sector;
    logic [22:0] logical_sector;
  } est_in_t;

  typedef struct packed {
    logic        past_end;
    logic        mapped;
    logic        remapped;
    logic [31:0] physical_sector;
    logic [9:0]  bytes_in_sector;
  } est_out_t;

  typedef struct packed {
    logic [31:0] file_length_bytes;
    logic [6:0]  extents_in_use;
    logic [8:0]  remaps_in_use;
  } est_cfg_t;

  typedef struct packed {
    logic [31:0] logical_start;
    logic [31:0] length;
    logic [31:0] physical_start;
  } est_ext_ent_t;

  typedef struct packed {
    logic [31:0] from_sector;
    logic [31:0] to_sector;
  } est_rem_ent_t;

endpackage

// ===== sv/extent_sector_translator_unit.sv =====
// Top level of the extent sector translator: configuration registers,
// the two table RAMs, the sequencer and the output register.
// Depends on est_pkg, est_ram and est_engine.
//
// Load items write one extent or remap entry in the cycle they are taken, and
// the next item may be accepted in the following cycle. A translate item whose
// sector lies past the end of the file goes straight to the result. For an
// unmapped sector every extent entry is searched, up to extents_in_use clipped
// to the table depth. For a mapped sector the extent scan stops at the first
// covering entry, and then every remap entry is searched, up to remaps_in_use
// clipped to the table depth; each table RAM has a single read port and one
// entry is read per cycle. A finished item sits in the output register while
// the next item is taken; it is held back only while that register is full
// and not being emptied. The tables have no reset value; only entries that
// have been loaded may be searched.
module extent_sector_translator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  est_pkg::est_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output est_pkg::est_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  est_pkg::cfg_idx_t         cfg_index,
  input  logic [est_pkg::CFG_DW-1:0] cfg_wdata
);
  import est_pkg::*;

  est_cfg_t     cfg_r, cfg_nxt;
  logic         out_valid_r, out_valid_nxt;
  est_out_t     out_data_r, out_data_nxt;

  logic         res_valid;
  logic         res_take;
  est_out_t     res_data;

  logic         ext_wr_en;
  ext_addr_t    ext_wr_addr;
  est_ext_ent_t ext_wr_data;
  ext_addr_t    ext_rd_addr;
  est_ext_ent_t ext_rd_data;
  logic         rem_wr_en;
  rem_addr_t    rem_wr_addr;
  est_rem_ent_t rem_wr_data;
  rem_addr_t    rem_rd_addr;
  est_rem_ent_t rem_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FILE_LENGTH:  cfg_nxt.file_length_bytes = cfg_wdata[31:0];
        CFG_EXTENTS_USED: cfg_nxt.extents_in_use    = cfg_wdata[6:0];
        CFG_REMAPS_USED:  cfg_nxt.remaps_in_use     = cfg_wdata[8:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // The result moves into the output register whenever that is empty or
  // being emptied in the same cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  est_ram #(
    .WIDTH ($bits(est_ext_ent_t)),
    .DEPTH (EXT_SLOTS)
  ) u_ext_ram (
    .clk     (clk),
    .wr_en   (ext_wr_en),
    .wr_addr (ext_wr_addr),
    .wr_data (ext_wr_data),
    .rd_addr (ext_rd_addr),
    .rd_data (ext_rd_data)
  );

  est_ram #(
    .WIDTH ($bits(est_rem_ent_t)),
    .DEPTH (REMAP_SLOTS)
  ) u_rem_ram (
    .clk     (clk),
    .wr_en   (rem_wr_en),
    .wr_addr (rem_wr_addr),
    .wr_data (rem_wr_data),
    .rd_addr (rem_rd_addr),
    .rd_data (rem_rd_data)
  );

  est_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_data    (res_data),
    .ext_wr_en   (ext_wr_en),
    .ext_wr_addr (ext_wr_addr),
    .ext_wr_data (ext_wr_data),
    .ext_rd_addr (ext_rd_addr),
    .ext_rd_data (ext_rd_data),
    .rem_wr_en   (rem_wr_en),
    .rem_wr_addr (rem_wr_addr),
    .rem_wr_data (rem_wr_data),
    .rem_rd_addr (rem_rd_addr),
    .rem_rd_data (rem_rd_data)
  );

endmodule

// ===== sv/est_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; instanced for both translation tables.
module est_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/est_engine.sv =====
// Sequencer of the translator: table loads, the extent scan, the physical
// offset and the bad-sector scan. Depends on est_pkg; drives both table RAMs.
module est_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  est_pkg::est_in_t        in_data,
  input  est_pkg::est_cfg_t       cfg,
  output logic                    res_valid,
  input  logic                    res_take,
  output est_pkg::est_out_t       res_data,
  output logic                    ext_wr_en,
  output est_pkg::ext_addr_t      ext_wr_addr,
  output est_pkg::est_ext_ent_t   ext_wr_data,
  output est_pkg::ext_addr_t      ext_rd_addr,
  input  est_pkg::est_ext_ent_t   ext_rd_data,
  output logic                    rem_wr_en,
  output est_pkg::rem_addr_t      rem_wr_addr,
  output est_pkg::est_rem_ent_t   rem_wr_data,
  output est_pkg::rem_addr_t      rem_rd_addr,
  input  est_pkg::est_rem_ent_t   rem_rd_data
);
  import est_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXT  = 5'b00010,
    S_PHYS = 5'b00100,
    S_REM  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  ext_cnt_t    ext_idx_r, ext_idx_nxt;
  ext_cnt_t    n_ext_r, n_ext_nxt;
  rem_cnt_t    rem_idx_r, rem_idx_nxt;
  rem_cnt_t    n_rem_r, n_rem_nxt;
  logic        chk_r, chk_nxt;
  logic [22:0] sector_r, sector_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] pstart_r, pstart_nxt;
  logic [31:0] target_r, target_nxt;
  est_out_t    res_r, res_nxt;

  logic        fire;
  logic [31:0] start_byte;
  logic [31:0] left_bytes;
  logic        past;
  logic [31:0] sector32;
  logic [32:0] ext_end;
  logic        ext_hit;

  assign in_ready  = (state_r == S_IDLE);
  assign fire      = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  // Loads write straight into the tables in the cycle they are taken.
  assign ext_wr_en   = fire && (req_type_t'(in_data.req_type) == REQ_LOAD_EXTENT)
                       && (32'(in_data.slot_index) < EXT_SLOTS);
  assign ext_wr_addr = ext_addr_t'(in_data.slot_index);
  assign ext_wr_data = '{logical_start:  in_data.extent_logical_first,
                         length:         in_data.extent_sector_count,
                         physical_start: in_data.extent_physical_first};
  assign rem_wr_en   = fire && (req_type_t'(in_data.req_type) == REQ_LOAD_REMAP)
                       && (32'(in_data.slot_index) < REMAP_SLOTS);
  assign rem_wr_addr = rem_addr_t'(in_data.slot_index);
  assign rem_wr_data = '{from_sector: in_data.bad_sector, to_sector: in_data.spare_sector};

  assign ext_rd_addr = ext_idx_r[EXT_AW-1:0];
  assign rem_rd_addr = rem_idx_r[REM_AW-1:0];

  assign start_byte = {in_data.logical_sector, 9'b0};
  assign past       = (start_byte >= cfg.file_length_bytes);
  assign left_bytes = cfg.file_length_bytes - start_byte;

  // The end of an extent is formed in 33 bits, so an extent never wraps.
  assign sector32 = {9'b0, sector_r};
  assign ext_end  = {1'b0, ext_rd_data.logical_start} + {1'b0, ext_rd_data.length};
  assign ext_hit  = (sector32 >= ext_rd_data.logical_start) && ({1'b0, sector32} < ext_end);

  always_comb begin
    state_nxt   = state_r;
    ext_idx_nxt = ext_idx_r;
    n_ext_nxt   = n_ext_r;
    rem_idx_nxt = rem_idx_r;
    n_rem_nxt   = n_rem_r;
    chk_nxt     = chk_r;
    sector_nxt  = sector_r;
    off_nxt     = off_r;
    pstart_nxt  = pstart_r;
    target_nxt  = target_r;
    res_nxt     = res_r;

    case (state_r)
      S_IDLE: begin
        if (fire && (req_type_t'(in_data.req_type) == REQ_TRANSLATE)) begin
          sector_nxt          = in_data.logical_sector;
          ext_idx_nxt         = '0;
          chk_nxt             = 1'b0;
          n_ext_nxt = (32'(cfg.extents_in_use) > EXT_SLOTS) ? ext_cnt_t'(EXT_SLOTS)
                                                             : ext_cnt_t'(cfg.extents_in_use);
          n_rem_nxt = (32'(cfg.remaps_in_use) > REMAP_SLOTS) ? rem_cnt_t'(REMAP_SLOTS)
                                                              : rem_cnt_t'(cfg.remaps_in_use);
          res_nxt             = '0;
          res_nxt.past_end    = past;
          if (past) begin
            state_nxt = S_DONE;
          end else begin
            res_nxt.bytes_in_sector = (left_bytes < 32'(SECTOR_BYTES)) ? left_bytes[9:0]
                                                                       : SECTOR_BYTES;
            state_nxt = S_EXT;
          end
        end
      end

      S_EXT: begin
        // One entry is read each cycle and checked in the next.
        if (ext_idx_r < n_ext_r) begin
          ext_idx_nxt = ext_idx_r + 1'b1;
          chk_nxt     = 1'b1;
        end else begin
          chk_nxt = 1'b0;
        end
        if (chk_r && ext_hit) begin
          off_nxt    = sector32 - ext_rd_data.logical_start;
          pstart_nxt = ext_rd_data.physical_start;
          state_nxt  = S_PHYS;
        end else if (!chk_r && !(ext_idx_r < n_ext_r)) begin
          state_nxt = S_DONE;
        end
      end

      S_PHYS: begin
        target_nxt              = pstart_r + off_r;
        res_nxt.mapped          = 1'b1;
        res_nxt.physical_sector = pstart_r + off_r;
        rem_idx_nxt             = '0;
        chk_nxt                 = 1'b0;
        state_nxt               = S_REM;
      end

      S_REM: begin
        // Every entry is visited; a later match overrides an earlier one.
        if (rem_idx_r < n_rem_r) begin
          rem_idx_nxt = rem_idx_r + 1'b1;
          chk_nxt     = 1'b1;
        end else begin
          chk_nxt = 1'b0;
        end
        if (chk_r && (rem_rd_data.from_sector == target_r)) begin
          res_nxt.remapped        = 1'b1;
          res_nxt.physical_sector = rem_rd_data.to_sector;
        end
        if (!chk_r && !(rem_idx_r < n_rem_r)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
    end
    ext_idx_r <= ext_idx_nxt;
    n_ext_r   <= n_ext_nxt;
    rem_idx_r <= rem_idx_nxt;
    n_rem_r   <= n_rem_nxt;
    sector_r  <= sector_nxt;
    off_r     <= off_nxt;
    pstart_r  <= pstart_nxt;
    target_r  <= target_nxt;
    res_r     <= res_nxt;
  end

endmodule
